[rtl/core/csvt_pkg.sv]
// Shared types and constants for the CSV byte tokenizer.
`default_nettype none
package csvt_pkg;

  localparam int unsigned CFG_W = 20;
  localparam logic [CFG_W-1:0] MAX_ROWS_RESET = 20'd1024;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  localparam logic [2:0] CLS_OTHER = 3'd0;
  localparam logic [2:0] CLS_QUOTE = 3'd1;
  localparam logic [2:0] CLS_COMMA = 3'd2;
  localparam logic [2:0] CLS_CR    = 3'd3;
  localparam logic [2:0] CLS_LF    = 3'd4;

  localparam logic [2:0] KIND_BYTE    = 3'd0;
  localparam logic [2:0] KIND_FEND    = 3'd1;
  localparam logic [2:0] KIND_ROW_END = 3'd2;
  localparam logic [2:0] KIND_ERR     = 3'd3;
  localparam logic [2:0] KIND_DONE    = 3'd4;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_STRAY   = 2'd1;
  localparam logic [1:0] ERR_UNTERM  = 2'd2;
  localparam logic [1:0] ERR_ROWS    = 2'd3;

  localparam logic [1:0] QM_OUT   = 2'd0;
  localparam logic [1:0] QM_IN    = 2'd1;
  localparam logic [1:0] QM_QSEEN = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } csvt_in_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] field_byte;
    logic [1:0] error_code;
    logic       last;
  } csvt_out_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [2:0] cls;
    logic       eos;
  } csvt_entry_t;

  typedef struct packed {
    logic        vld;
    csvt_entry_t ent;
  } csvt_head_t;

endpackage
`default_nettype wire

[rtl/core/csvt_front.sv]
// Input side: accepts bytes, classifies them and holds them in a two-entry queue.
`default_nettype none
module csvt_front
  import csvt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire csvt_in_t   in_item,
  output csvt_head_t      head,
  input  wire logic       pop
);

  csvt_entry_t q_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  count_r;
  logic        wr_ptr_nxt;
  logic        rd_ptr_nxt;
  logic [1:0]  count_nxt;
  logic        push;
  csvt_entry_t new_ent;

  always_comb begin
    new_ent.data_byte = in_item.data_byte;
    new_ent.eos       = in_item.end_of_stream;
    case (in_item.data_byte)
      CH_QUOTE: new_ent.cls = CLS_QUOTE;
      CH_COMMA: new_ent.cls = CLS_COMMA;
      CH_CR:    new_ent.cls = CLS_CR;
      CH_LF:    new_ent.cls = CLS_LF;
      default:  new_ent.cls = CLS_OTHER;
    endcase
  end

  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid && !in_stall;

  assign head.vld = (count_r != 2'd0);
  assign head.ent = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= new_ent;
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != 2'd0)
    else $error("queue popped while empty");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("queue count out of range");

  a_full_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd2) && pop |=> count_r == 2'd1)
    else $error("queue accepted a transfer while full");

endmodule
`default_nettype wire

[rtl/core/csvt_back.sv]
// Tokenizer state machine and output register fed from the input queue.
`default_nettype none
module csvt_back
  import csvt_pkg::*;
#(
  parameter int unsigned MW = 20
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire csvt_head_t    head,
  output logic               pop,
  input  wire logic [MW-1:0] row_limit,
  output logic               out_valid,
  input  wire logic          out_stall,
  output csvt_out_t          out_item
);

  logic [1:0]    qm_r, qm_nxt;
  logic          content_r, content_nxt;
  logic          rowf_r, rowf_nxt;
  logic          skip_r, skip_nxt;
  logic [MW-1:0] rows_r, rows_nxt;
  logic          hold_r, hold_nxt;
  logic          pend_done_r, pend_done_nxt;
  logic          out_valid_r, out_valid_nxt;
  csvt_out_t     out_item_r;
  csvt_out_t     cand;
  logic          cand_vld;
  logic          two;
  logic          load_ok;
  logic          load;
  logic          blank;
  logic          over;

  assign load_ok = !out_valid_r || !out_stall;
  assign pop     = !pend_done_r && head.vld && load_ok;
  assign blank   = !content_r && !rowf_r;
  assign over    = (rows_r >= row_limit);

  always_comb begin
    qm_nxt      = qm_r;
    content_nxt = content_r;
    rowf_nxt    = rowf_r;
    skip_nxt    = skip_r;
    rows_nxt    = rows_r;
    hold_nxt    = hold_r;
    cand        = '0;
    cand_vld    = 1'b0;
    two         = 1'b0;
    if (pend_done_r) begin
      cand.kind = KIND_DONE;
      cand.last = 1'b1;
      cand_vld  = 1'b1;
    end else if (pop) begin
      if (head.ent.eos) begin
        cand_vld  = 1'b1;
        cand.kind = KIND_DONE;
        cand.last = 1'b1;
        if (!hold_r) begin
          if (qm_r == QM_IN) begin
            cand.kind       = KIND_ERR;
            cand.error_code = ERR_UNTERM;
            cand.last       = 1'b0;
            two             = 1'b1;
          end else if (!blank) begin
            cand.last = 1'b0;
            two       = 1'b1;
            if (over) begin
              cand.kind       = KIND_ERR;
              cand.error_code = ERR_ROWS;
            end else begin
              cand.kind = KIND_ROW_END;
            end
          end
        end
        qm_nxt      = QM_OUT;
        content_nxt = 1'b0;
        rowf_nxt    = 1'b0;
        skip_nxt    = 1'b0;
        rows_nxt    = '0;
        hold_nxt    = 1'b0;
      end else if (!hold_r) begin
        skip_nxt  = 1'b0;
        cand.last = 1'b1;
        if (!(skip_r && head.ent.cls == CLS_LF)) begin
          if (qm_r == QM_IN) begin
            if (head.ent.cls == CLS_QUOTE) begin
              qm_nxt = QM_QSEEN;
            end else begin
              content_nxt     = 1'b1;
              cand_vld        = 1'b1;
              cand.kind       = KIND_BYTE;
              cand.field_byte = head.ent.data_byte;
            end
          end else if (qm_r == QM_QSEEN && head.ent.cls == CLS_QUOTE) begin
            qm_nxt          = QM_IN;
            content_nxt     = 1'b1;
            cand_vld        = 1'b1;
            cand.kind       = KIND_BYTE;
            cand.field_byte = head.ent.data_byte;
          end else begin
            qm_nxt = QM_OUT;
            case (head.ent.cls)
              CLS_QUOTE: begin
                if (content_r) begin
                  hold_nxt        = 1'b1;
                  cand_vld        = 1'b1;
                  cand.kind       = KIND_ERR;
                  cand.error_code = ERR_STRAY;
                end else begin
                  qm_nxt = QM_IN;
                end
              end
              CLS_COMMA: begin
                content_nxt = 1'b0;
                rowf_nxt    = 1'b1;
                cand_vld    = 1'b1;
                cand.kind   = KIND_FEND;
              end
              CLS_CR, CLS_LF: begin
                skip_nxt    = (head.ent.cls == CLS_CR);
                content_nxt = 1'b0;
                rowf_nxt    = 1'b0;
                if (!blank) begin
                  cand_vld = 1'b1;
                  if (over) begin
                    hold_nxt        = 1'b1;
                    cand.kind       = KIND_ERR;
                    cand.error_code = ERR_ROWS;
                  end else begin
                    rows_nxt  = rows_r + 1'b1;
                    cand.kind = KIND_ROW_END;
                  end
                end
              end
              default: begin
                content_nxt     = 1'b1;
                cand_vld        = 1'b1;
                cand.kind       = KIND_BYTE;
                cand.field_byte = head.ent.data_byte;
              end
            endcase
          end
        end
      end
    end
  end

  assign load = ((pend_done_r && load_ok) || pop) && cand_vld;

  always_comb begin
    pend_done_nxt = pend_done_r;
    if (pend_done_r && load_ok) begin
      pend_done_nxt = 1'b0;
    end else if (pop && two) begin
      pend_done_nxt = 1'b1;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qm_r        <= QM_OUT;
      content_r   <= 1'b0;
      rowf_r      <= 1'b0;
      skip_r      <= 1'b0;
      rows_r      <= '0;
      hold_r      <= 1'b0;
      pend_done_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      qm_r        <= qm_nxt;
      content_r   <= content_nxt;
      rowf_r      <= rowf_nxt;
      skip_r      <= skip_nxt;
      rows_r      <= rows_nxt;
      hold_r      <= hold_nxt;
      pend_done_r <= pend_done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item_r <= cand;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_pend_has_out: assert property (@(posedge clk) disable iff (!rst_n)
    pend_done_r |-> out_valid_r && !out_item_r.last)
    else $error("pending done without a first result in the output register");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.kind == KIND_DONE |-> out_item_r.last)
    else $error("done token without last");

  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.kind != KIND_BYTE |-> out_item_r.field_byte == 8'd0)
    else $error("field byte set on a non-byte token");

  a_code_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_item_r.error_code != ERR_NONE) == (out_item_r.kind == KIND_ERR))
    else $error("error code does not match token kind");

endmodule
`default_nettype wire

[rtl/core/csv_byte_tokenizer.sv]
// Top level of the streaming CSV byte tokenizer.
// The tokenizer takes one byte of CSV text per transfer and sustains one byte
// per cycle while out_stall is low and no second end-of-stream token waits;
// every byte yields at most one token. An end-of-stream transfer that closes
// a non-empty row or an open quote yields two tokens, which the single output
// register carries one after the other. Bytes pass through a two-entry queue
// and then the tokenizer state machine into the registered output.
// The row limit register may be written at any time the block is idle; it is
// written through cfg_data and is always ready.
`default_nettype none
module csv_byte_tokenizer
  import csvt_pkg::*;
#(
  parameter int unsigned ROW_COUNT_WIDTH = 20
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire csvt_in_t         in_item,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output csvt_out_t             out_item,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CFG_W-1:0] cfg_data
);

  localparam int unsigned MW = (ROW_COUNT_WIDTH < CFG_W) ? ROW_COUNT_WIDTH : CFG_W;

  logic [MW-1:0] row_limit_r;
  csvt_head_t    head;
  logic          pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_limit_r <= MW'(MAX_ROWS_RESET);
    end else if (cfg_valid && cfg_ready) begin
      row_limit_r <= MW'(cfg_data);
    end
  end

  csvt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .head     (head),
    .pop      (pop)
  );

  csvt_back #(
    .MW (MW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .row_limit (row_limit_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire
